// ----- rtl/core/fsp_pkg.sv -----
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared constants and codes for the fixed-slot cell pair generator.
// ----------------------------------------------------------------------------
`default_nettype none

package fsp_pkg;

   // Geometry of the cell list
   localparam int unsigned MAX_CELLS       = 1024;
   localparam int unsigned CELL_BITS       = 10;
   localparam int unsigned CELL_REQ_BITS   = 11;
   localparam int unsigned SLOTS_PER_CELL  = 16;
   localparam int unsigned SLOT_BITS       = 4;
   localparam int unsigned NEIGHBOUR_CELLS = 27;
   localparam int unsigned ORD_BITS        = 5;
   localparam int unsigned ID_BITS         = 16;
   localparam int unsigned FILL_BITS       = 5;
   localparam int unsigned ADDR_BITS       = 24;
   localparam int unsigned COUNT_BITS      = 9;

   // Memory shapes
   localparam int unsigned NB_DEPTH        = MAX_CELLS * NEIGHBOUR_CELLS;
   localparam int unsigned NB_ABITS        = $clog2(NB_DEPTH);
   localparam int unsigned SLOT_DEPTH      = MAX_CELLS * SLOTS_PER_CELL;
   localparam int unsigned SLOT_ABITS      = $clog2(SLOT_DEPTH);

   // Request function codes
   typedef enum logic [2:0] {
      FUNC_NBR   = 3'd0,
      FUNC_SLOT  = 3'd1,
      FUNC_FILL  = 3'd2,
      FUNC_COUNT = 3'd3,
      FUNC_EMIT  = 3'd4
   } func_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_CELLS_IN_USE = 2'd0;
   localparam logic [1:0] CSR_OBSTACLES    = 2'd1;
   localparam logic [1:0] CSR_PAIR_OFFSET  = 2'd2;

   // Result kinds
   localparam logic KIND_PAIR  = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/core/fsp_ram.sv -----
// ----------------------------------------------------------------------------
// fsp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and read; read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/fixed_slot_cell_pair_generator.sv -----
// Sequence: a load is written to its RAM when accepted; an emit request reads one
// neighbour entry, checks that cell's fill, then reads each of its slots and ends by
// flushing the final pair. A count request walks all 27 neighbours the same way.
// One request at a time; a single RAM read port per store, walked by the sequencer,
// sets the rate, and a stalled result channel can hold the sequencer.
// Reset: a clearing pass over the 1024 fill entries runs first, no request taken.
// ----------------------------------------------------------------------------
// fixed_slot_cell_pair_generator
// Cell-list neighbour pair engine with fixed particle slots per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_slot_cell_pair_generator
   import fsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: cell_req[10:0], ordinal[15:11], slot[19:16], entry_value[35:20],
   //        query_particle[51:36], base_index[75:52], zero fill
   input  wire logic [79:0] req_tdata,
   // tuser: func[2:0]
   input  wire logic [2:0]  req_tuser,
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: pair_low[15:0], pair_high[31:16], pair_address[55:32],
   //        count_slot[71:56], pair_count[80:72], zero fill
   output logic [87:0]      rsp_tdata,
   // tuser: kind[0]
   output logic [0:0]       rsp_tuser,
   output logic             rsp_tlast,
   // configuration channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_data
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_NB_RD, ST_NB_CHK, ST_FILL_CHK,
      ST_SLOT_RD, ST_SLOT_CHK, ST_FLUSH, ST_COUNT_OUT
   } state_type;

   // Unpack request
   logic [CELL_REQ_BITS-1:0] req_cell;
   logic [ORD_BITS-1:0]      req_ord;
   logic [SLOT_BITS-1:0]     req_slot;
   logic [ID_BITS-1:0]       req_value;
   logic [ID_BITS-1:0]       req_qid;
   logic [ADDR_BITS-1:0]     req_base;
   logic                     req_fire;

   assign req_cell  = req_tdata[10:0];
   assign req_ord   = req_tdata[15:11];
   assign req_slot  = req_tdata[19:16];
   assign req_value = req_tdata[35:20];
   assign req_qid   = req_tdata[51:36];
   assign req_base  = req_tdata[75:52];

   // Registers
   state_type               state_ff, state_in;
   logic [CELL_REQ_BITS-1:0] cells_ff, cells_in;
   logic [ID_BITS-1:0]      obst_ff, obst_in;
   logic [ADDR_BITS-1:0]    offset_ff, offset_in;
   logic [ADDR_BITS-1:0]    wp_ff, wp_in;
   logic [CELL_BITS-1:0]    clr_ff, clr_in;
   logic [CELL_BITS-1:0]    home_ff, home_in;
   logic [CELL_BITS-1:0]    nc_ff, nc_in;
   logic [ID_BITS-1:0]      qid_ff, qid_in;
   logic [ORD_BITS-1:0]     ord_ff, ord_in;
   logic [FILL_BITS-1:0]    slot_ff, slot_in;
   logic [FILL_BITS-1:0]    fill_ff, fill_in;
   logic [COUNT_BITS-1:0]   total_ff, total_in;
   logic                    count_mode_ff, count_mode_in;
   logic                    pend_ff, pend_in;
   logic [ID_BITS-1:0]      pend_low_ff, pend_low_in;
   logic [ID_BITS-1:0]      pend_high_ff, pend_high_in;
   logic [ADDR_BITS-1:0]    pend_addr_ff, pend_addr_in;
   logic                    rv_ff, rv_in;
   logic                    rkind_ff, rkind_in;
   logic                    rlast_ff, rlast_in;
   logic [ID_BITS-1:0]      rlow_ff, rlow_in;
   logic [ID_BITS-1:0]      rhigh_ff, rhigh_in;
   logic [ADDR_BITS-1:0]    raddr_ff, raddr_in;
   logic [ID_BITS-1:0]      rcslot_ff, rcslot_in;
   logic [COUNT_BITS-1:0]   rcount_ff, rcount_in;

   // RAM ports
   logic                    nb_we, nb_re;
   logic [NB_ABITS-1:0]     nb_waddr, nb_raddr;
   logic [CELL_REQ_BITS-1:0] nb_rdata;
   logic                    sl_we, sl_re;
   logic [SLOT_ABITS-1:0]   sl_waddr, sl_raddr;
   logic [ID_BITS-1:0]      sl_rdata;
   logic                    fl_we, fl_re;
   logic [CELL_BITS-1:0]    fl_waddr, fl_raddr;
   logic [FILL_BITS-1:0]    fl_wdata, fl_rdata;

   logic                    out_free;
   logic                    nb_ok;
   logic                    partner;
   logic                    req_cell_ok;
   logic [FILL_BITS-1:0]    slot_next;

   // Cell index times 27 by shifts and adds
   function automatic logic [NB_ABITS-1:0] nb_base(input logic [CELL_BITS-1:0] c);
      logic [NB_ABITS-1:0] w;
      begin
         w = NB_ABITS'(c);
         return (w << 4) + (w << 3) + (w << 1) + w;
      end
   endfunction

   fsp_ram #(.WIDTH(CELL_REQ_BITS), .DEPTH(NB_DEPTH)) u_nb_ram (
      .clock(clock), .wr_en(nb_we), .wr_addr(nb_waddr), .wr_data(req_value[10:0]),
      .rd_en(nb_re), .rd_addr(nb_raddr), .rd_data(nb_rdata)
   );

   fsp_ram #(.WIDTH(ID_BITS), .DEPTH(SLOT_DEPTH)) u_slot_ram (
      .clock(clock), .wr_en(sl_we), .wr_addr(sl_waddr), .wr_data(req_value),
      .rd_en(sl_re), .rd_addr(sl_raddr), .rd_data(sl_rdata)
   );

   fsp_ram #(.WIDTH(FILL_BITS), .DEPTH(MAX_CELLS)) u_fill_ram (
      .clock(clock), .wr_en(fl_we), .wr_addr(fl_waddr), .wr_data(fl_wdata),
      .rd_en(fl_re), .rd_addr(fl_raddr), .rd_data(fl_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rv_ff || rsp_tready;
   assign req_cell_ok = !req_cell[10] && (req_cell < cells_ff);

   // Neighbour check: valid cell and not below home
   assign nb_ok = !nb_rdata[10] && (nb_rdata < cells_ff) &&
                  (nb_rdata[CELL_BITS-1:0] >= home_ff);
   // Partner check: inside home cell only higher ids count
   assign partner   = !((nc_ff == home_ff) && (qid_ff >= sl_rdata));
   assign slot_next = slot_ff + FILL_BITS'(1);

   // Memory writes from load requests and the clearing pass
   always_comb begin
      nb_we    = req_fire && (func_type'(req_tuser) == FUNC_NBR) && !req_cell[10] &&
                 (req_ord < ORD_BITS'(NEIGHBOUR_CELLS));
      nb_waddr = nb_base(req_cell[CELL_BITS-1:0]) + NB_ABITS'(req_ord);
      sl_we    = req_fire && (func_type'(req_tuser) == FUNC_SLOT) && !req_cell[10];
      sl_waddr = {req_cell[CELL_BITS-1:0], req_slot};
      if (state_ff == ST_CLEAR) begin
         fl_we    = 1'b1;
         fl_waddr = clr_ff;
         fl_wdata = '0;
      end else begin
         fl_we    = req_fire && (func_type'(req_tuser) == FUNC_FILL) && !req_cell[10];
         fl_waddr = req_cell[CELL_BITS-1:0];
         fl_wdata = (req_value > ID_BITS'(SLOTS_PER_CELL)) ? FILL_BITS'(SLOTS_PER_CELL)
                                                           : req_value[FILL_BITS-1:0];
      end
   end

   // Memory reads issued by the sequencer
   always_comb begin
      nb_re    = (state_ff == ST_NB_RD);
      nb_raddr = nb_base(home_ff) + NB_ABITS'(ord_ff);
      fl_re    = (state_ff == ST_NB_CHK);
      fl_raddr = nb_rdata[CELL_BITS-1:0];
      sl_re    = (state_ff == ST_SLOT_RD);
      sl_raddr = {nc_ff, slot_ff[SLOT_BITS-1:0]};
   end

   // Sequencer and result register next state
   always_comb begin
      state_in      = state_ff;
      cells_in      = cells_ff;
      obst_in       = obst_ff;
      offset_in     = offset_ff;
      wp_in         = wp_ff;
      clr_in        = clr_ff;
      home_in       = home_ff;
      nc_in         = nc_ff;
      qid_in        = qid_ff;
      ord_in        = ord_ff;
      slot_in       = slot_ff;
      fill_in       = fill_ff;
      total_in      = total_ff;
      count_mode_in = count_mode_ff;
      pend_in       = pend_ff;
      pend_low_in   = pend_low_ff;
      pend_high_in  = pend_high_ff;
      pend_addr_in  = pend_addr_ff;
      rv_in         = rv_ff && !rsp_tready;
      rkind_in      = rkind_ff;
      rlast_in      = rlast_ff;
      rlow_in       = rlow_ff;
      rhigh_in      = rhigh_ff;
      raddr_in      = raddr_ff;
      rcslot_in     = rcslot_ff;
      rcount_in     = rcount_ff;

      // Configuration writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CELLS_IN_USE: cells_in  = csr_data[CELL_REQ_BITS-1:0];
            CSR_OBSTACLES:    obst_in   = csr_data[ID_BITS-1:0];
            CSR_PAIR_OFFSET:  offset_in = csr_data;
            default:          ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + CELL_BITS'(1);
            if (clr_ff == CELL_BITS'(MAX_CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               home_in  = req_cell[CELL_BITS-1:0];
               qid_in   = req_qid;
               total_in = '0;
               pend_in  = 1'b0;
               case (func_type'(req_tuser))
                  FUNC_COUNT: begin
                     count_mode_in = 1'b1;
                     ord_in        = '0;
                     state_in      = req_cell_ok ? ST_NB_RD : ST_COUNT_OUT;
                  end
                  FUNC_EMIT: begin
                     count_mode_in = 1'b0;
                     ord_in        = req_ord;
                     if (req_ord == '0) begin
                        wp_in = offset_ff + req_base;
                     end
                     if (req_cell_ok && (req_ord < ORD_BITS'(NEIGHBOUR_CELLS))) begin
                        state_in = ST_NB_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_NB_RD: begin
            state_in = ST_NB_CHK;
         end
         ST_NB_CHK: begin
            nc_in = nb_rdata[CELL_BITS-1:0];
            if (nb_ok) begin
               state_in = ST_FILL_CHK;
            end else if (!count_mode_ff) begin
               state_in = ST_FLUSH;
            end else if (ord_ff == ORD_BITS'(NEIGHBOUR_CELLS - 1)) begin
               state_in = ST_COUNT_OUT;
            end else begin
               ord_in   = ord_ff + ORD_BITS'(1);
               state_in = ST_NB_RD;
            end
         end
         ST_FILL_CHK: begin
            fill_in = fl_rdata;
            slot_in = '0;
            if (fl_rdata != '0) begin
               state_in = ST_SLOT_RD;
            end else if (!count_mode_ff) begin
               state_in = ST_FLUSH;
            end else if (ord_ff == ORD_BITS'(NEIGHBOUR_CELLS - 1)) begin
               state_in = ST_COUNT_OUT;
            end else begin
               ord_in   = ord_ff + ORD_BITS'(1);
               state_in = ST_NB_RD;
            end
         end
         ST_SLOT_RD: begin
            state_in = ST_SLOT_CHK;
         end
         ST_SLOT_CHK: begin
            // Hold while a pending pair cannot move to the result register
            if (!(partner && !count_mode_ff && pend_ff && !out_free)) begin
               if (partner) begin
                  if (count_mode_ff) begin
                     total_in = total_ff + COUNT_BITS'(1);
                  end else begin
                     if (pend_ff) begin
                        rv_in     = 1'b1;
                        rkind_in  = KIND_PAIR;
                        rlast_in  = 1'b0;
                        rlow_in   = pend_low_ff;
                        rhigh_in  = pend_high_ff;
                        raddr_in  = pend_addr_ff;
                        rcslot_in = '0;
                        rcount_in = '0;
                     end
                     pend_in      = 1'b1;
                     pend_low_in  = (qid_ff < sl_rdata) ? qid_ff : sl_rdata;
                     pend_high_in = (qid_ff < sl_rdata) ? sl_rdata : qid_ff;
                     pend_addr_in = wp_ff;
                     wp_in        = wp_ff + ADDR_BITS'(1);
                  end
               end
               slot_in = slot_next;
               if (slot_next < fill_ff) begin
                  state_in = ST_SLOT_RD;
               end else if (!count_mode_ff) begin
                  state_in = ST_FLUSH;
               end else if (ord_ff == ORD_BITS'(NEIGHBOUR_CELLS - 1)) begin
                  state_in = ST_COUNT_OUT;
               end else begin
                  ord_in   = ord_ff + ORD_BITS'(1);
                  state_in = ST_NB_RD;
               end
            end
         end
         ST_FLUSH: begin
            // Send the final pair with last set
            if (!pend_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rv_in     = 1'b1;
               rkind_in  = KIND_PAIR;
               rlast_in  = 1'b1;
               rlow_in   = pend_low_ff;
               rhigh_in  = pend_high_ff;
               raddr_in  = pend_addr_ff;
               rcslot_in = '0;
               rcount_in = '0;
               pend_in   = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         ST_COUNT_OUT: begin
            if (out_free) begin
               rv_in     = 1'b1;
               rkind_in  = KIND_COUNT;
               rlast_in  = 1'b1;
               rlow_in   = '0;
               rhigh_in  = '0;
               raddr_in  = '0;
               rcslot_in = qid_ff - obst_ff;
               rcount_in = total_ff;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         cells_ff  <= CELL_REQ_BITS'(MAX_CELLS);
         obst_ff   <= '0;
         offset_ff <= '0;
         wp_ff     <= '0;
         clr_ff    <= '0;
         pend_ff   <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cells_ff  <= cells_in;
         obst_ff   <= obst_in;
         offset_ff <= offset_in;
         wp_ff     <= wp_in;
         clr_ff    <= clr_in;
         pend_ff   <= pend_in;
         rv_ff     <= rv_in;
      end
      home_ff       <= home_in;
      nc_ff         <= nc_in;
      qid_ff        <= qid_in;
      ord_ff        <= ord_in;
      slot_ff       <= slot_in;
      fill_ff       <= fill_in;
      total_ff      <= total_in;
      count_mode_ff <= count_mode_in;
      pend_low_ff   <= pend_low_in;
      pend_high_ff  <= pend_high_in;
      pend_addr_ff  <= pend_addr_in;
      rkind_ff      <= rkind_in;
      rlast_ff      <= rlast_in;
      rlow_ff       <= rlow_in;
      rhigh_ff      <= rhigh_in;
      raddr_ff      <= raddr_in;
      rcslot_ff     <= rcslot_in;
      rcount_ff     <= rcount_in;
   end

   // Drive the result channel
   assign rsp_tvalid = rv_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tuser  = rkind_ff;
   assign rsp_tdata  = {7'd0, rcount_ff, rcslot_ff, raddr_ff, rhigh_ff, rlow_ff};

endmodule

`default_nettype wire
